// File: src/stld_pkg.sv
// Shared constants, types and helpers for the serial tagged line deframer.
package stld_pkg;

  localparam int unsigned LINE_BUF_LEN = 64;
  localparam int unsigned LINE_AW      = $clog2(LINE_BUF_LEN);

  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_TWO   = 8'h32;

  // Prefix length stripped from a tagged line.
  localparam logic [LINE_AW-1:0] TAG_LEN = LINE_AW'(2);

  typedef enum logic [1:0] {
    KIND_EP      = 2'd0,
    KIND_CONTROL = 2'd1,
    KIND_INFO    = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WR2,
    ST_EMIT
  } state_e;

  // One write to the line RAM.
  typedef struct packed {
    logic               en;
    logic [LINE_AW-1:0] addr;
    logic [7:0]         data;
  } ram_wr_t;

  function automatic logic is_tag_digit(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_TWO);
  endfunction

endpackage

// File: src/stld_line_ram.sv
// Line buffer RAM: one write port, one read port with registered read data.
module stld_line_ram
  import stld_pkg::*;
(
  input  logic               clk_i,
  input  ram_wr_t            wr_i,
  input  logic               rd_en_i,
  input  logic [LINE_AW-1:0] rd_addr_i,
  output logic [7:0]         rd_data_o
);

  logic [7:0] mem_q [LINE_BUF_LEN];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: src/serial_tagged_line_deframer_unit.sv
// Top level: serial byte deframer building tagged CR-terminated lines.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+----------------------------------
//   rx in   | input     | in_valid_i/in_ready_o  | rx_byte_i[7:0]
//   line out| output    | out_valid_o/out_ready_i| line_char_o, line_kind_o, line_end_o
//
// A plain byte or LF is taken in ST_IDLE without leaving it. A resync colon
// also passes through ST_WR2, since the RAM has one write port and the restarted
// line needs two entries written. A CR with a non-empty line holds the input in
// ST_EMIT while its characters (up to LINE_BUF_LEN-1) go out via the single RAM read port.
// Reset clears the fill count, the state and the output valid; RAM contents
// stay undefined, and only entries written in the current line are ever read.
// A stalled output word holds in the RAM read register; the next byte may be
// accepted while the last word of a line still waits.
module serial_tagged_line_deframer_unit
  import stld_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] line_char_o,
  output logic [1:0] line_kind_o,
  output logic       line_end_o
);

  state_e state_q, state_d;

  // Line bookkeeping. head0/head1/last shadow RAM entries 0, 1 and fill-1,
  // so the tag and resync checks never need a RAM read.
  logic [LINE_AW-1:0] fill_q, fill_d;
  logic [7:0]         head0_q, head0_d;
  logic [7:0]         head1_q, head1_d;
  logic [7:0]         last_q, last_d;

  // Emission pointers.
  logic [LINE_AW-1:0] idx_q, idx_d;
  logic [LINE_AW-1:0] end_q, end_d;
  kind_e              kind_q, kind_d;

  // Output word sideband (char comes straight from the RAM read register).
  logic  out_valid_q, out_valid_d;
  kind_e out_kind_q, out_kind_d;
  logic  out_end_q, out_end_d;

  ram_wr_t            ram_wr;
  logic               rd_en;
  logic [7:0]         rd_data;

  logic               acc;
  logic               has_tag;
  logic [LINE_AW-1:0] start;
  logic               resync;
  kind_e              tag_kind;

  assign acc = in_valid_i && in_ready_o;

  // Tag prefix seen at CR: digit then colon in the first two entries.
  assign has_tag = (fill_q >= TAG_LEN) && (head1_q == CHAR_COLON) && is_tag_digit(head0_q);
  assign start   = has_tag ? TAG_LEN : '0;

  // Colon right after a tag digit restarts the line on that digit,
  // unless the line already carries a prefix.
  assign resync = (rx_byte_i == CHAR_COLON) && (fill_q >= TAG_LEN) &&
                  (head1_q != CHAR_COLON) && is_tag_digit(last_q);

  always_comb begin
    unique case (head0_q)
      CHAR_ZERO: tag_kind = KIND_CONTROL;
      CHAR_TWO:  tag_kind = KIND_INFO;
      default:   tag_kind = KIND_EP;
    endcase
  end

  // During emission, issue a RAM read whenever the output register is free or being drained.
  assign rd_en = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d      = state_q;
    fill_d       = fill_q;
    head0_d      = head0_q;
    head1_d      = head1_q;
    last_d       = last_q;
    idx_d        = idx_q;
    end_d        = end_q;
    kind_d       = kind_q;
    in_ready_o   = 1'b0;
    ram_wr.en    = 1'b0;
    ram_wr.addr  = fill_q;
    ram_wr.data  = rx_byte_i;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (acc) begin
          priority if (rx_byte_i == CHAR_LF) begin
            // dropped
          end else if (rx_byte_i == CHAR_CR) begin
            fill_d = '0;
            idx_d  = start;
            end_d  = fill_q - LINE_AW'(1);
            kind_d = has_tag ? tag_kind : KIND_EP;
            if (fill_q > start) begin
              state_d = ST_EMIT;
            end
          end else if (resync) begin
            // entry 0 now, the colon into entry 1 next cycle
            ram_wr.en   = 1'b1;
            ram_wr.addr = '0;
            ram_wr.data = last_q;
            head0_d     = last_q;
            head1_d     = CHAR_COLON;
            last_d      = CHAR_COLON;
            fill_d      = TAG_LEN;
            state_d     = ST_WR2;
          end else if (fill_q < LINE_AW'(LINE_BUF_LEN - 1)) begin
            ram_wr.en = 1'b1;
            if (fill_q == '0) begin
              head0_d = rx_byte_i;
            end
            if (fill_q == LINE_AW'(1)) begin
              head1_d = rx_byte_i;
            end
            last_d = rx_byte_i;
            fill_d = fill_q + LINE_AW'(1);
          end else begin
            // overflow: byte dropped, line discarded
            fill_d = '0;
          end
        end
      end
      ST_WR2: begin
        ram_wr.en   = 1'b1;
        ram_wr.addr = LINE_AW'(1);
        ram_wr.data = CHAR_COLON;
        state_d     = ST_IDLE;
      end
      ST_EMIT: begin
        if (rd_en) begin
          idx_d = idx_q + LINE_AW'(1);
          if (idx_q == end_q) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_kind_d  = out_kind_q;
    out_end_d   = out_end_q;
    if (rd_en) begin
      out_valid_d = 1'b1;
      out_kind_d  = kind_q;
      out_end_d   = (idx_q == end_q);
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head0_q    <= head0_d;
    head1_q    <= head1_d;
    last_q     <= last_d;
    idx_q      <= idx_d;
    end_q      <= end_d;
    kind_q     <= kind_d;
    out_kind_q <= out_kind_d;
    out_end_q  <= out_end_d;
  end

  stld_line_ram u_line_ram (
    .clk_i     (clk_i),
    .wr_i      (ram_wr),
    .rd_en_i   (rd_en),
    .rd_addr_i (idx_q),
    .rd_data_o (rd_data)
  );

  assign out_valid_o = out_valid_q;
  assign line_char_o = rd_data;
  assign line_kind_o = out_kind_q;
  assign line_end_o  = out_end_q;

  // RAM port use never overlaps: writes only outside emission.
  a_no_wr_during_rd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_wr.en && rd_en))
    else $error("RAM write and read issued together");

  // An accepted CR always clears the fill count.
  a_cr_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && rx_byte_i == CHAR_CR) |=> (fill_q == '0))
    else $error("fill count not cleared after CR");

  // The second resync write state is always followed directly by ST_IDLE.
  a_wr2_one_cycle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WR2) |=> (state_q == ST_IDLE))
    else $error("resync write state stuck");

  // A resync leaves a two-entry line with a colon second.
  a_resync_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && resync && rx_byte_i != CHAR_CR && rx_byte_i != CHAR_LF)
      |=> (fill_q == TAG_LEN && head1_q == CHAR_COLON))
    else $error("resync left wrong line state");

  // A read only loads the output when it is empty or its word is being taken.
  a_rd_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> (!out_valid_q || out_ready_i))
    else $error("output word overwritten while stalled");

endmodule

// File: tb/sv/tb_serial_tagged_line_deframer_unit.sv
// Testbench for the serial tagged line deframer: directed and random bytes, word-level check.
`timescale 1ns / 1ps

module tb_serial_tagged_line_deframer_unit;
  import stld_pkg::*;

  // Watchdog limit, with a wide margin over the slowest legal run.
  localparam int unsigned CYCLE_LIMIT  = 200000;
  // Cycles after the last expected word, to catch stray output words.
  localparam int unsigned DRAIN_CYCLES = 150;
  localparam int unsigned MAX_IDLE     = 5;

  // One expected output word of an emitted line.
  typedef struct {
    logic [7:0] ch;
    kind_e      kind;
    logic       last;
  } line_word_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] rx_byte_i   = 8'h00;
  logic       out_ready_i = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [7:0] line_char_o;
  logic [1:0] line_kind_o;
  logic       line_end_o;

  // Predictor state: mirror of the line buffer and its fill level.
  logic [7:0]  line_buf [LINE_BUF_LEN];
  int unsigned line_len = 0;

  line_word_t  pending_words[$];
  int unsigned fail_count  = 0;
  int unsigned bytes_sent  = 0;  // LF bytes excluded, the block ignores them
  int unsigned cycle_count = 0;
  bit          idle_en     = 1'b0;

  serial_tagged_line_deframer_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rx_byte_i   (rx_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .line_char_o (line_char_o),
    .line_kind_o (line_kind_o),
    .line_end_o  (line_end_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: watchdog expired, %0d words still pending", $realtime,
               pending_words.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Line predictor: consumes one accepted byte, queues the words it releases.
  task automatic deframe_byte(input logic [7:0] c);
    kind_e       kind;
    int unsigned first;
    logic [7:0]  prev;
    line_word_t  w;
    kind  = KIND_EP;
    first = 0;
    if (c == CHAR_LF) begin
      return;
    end
    if (c == CHAR_CR) begin
      // Strip a "<digit 0..2>:" tag; digit 0 is control, 1 energy point, 2 info.
      if (line_len >= 2 && line_buf[1] == CHAR_COLON &&
          line_buf[0] inside {[CHAR_ZERO:CHAR_TWO]}) begin
        if (line_buf[0] == CHAR_ZERO) begin
          kind = KIND_CONTROL;
        end else if (line_buf[0] == CHAR_TWO) begin
          kind = KIND_INFO;
        end
        first = 2;
      end
      for (int unsigned i = first; i < line_len; i++) begin
        w.ch   = line_buf[i];
        w.kind = kind;
        w.last = (i + 1 == line_len);
        pending_words.push_back(w);
      end
      line_len = 0;
      return;
    end
    // A colon right after a tag digit restarts the line on that digit,
    // unless the line already carries a tag.
    if (c == CHAR_COLON && line_len >= 2 && line_buf[1] != CHAR_COLON) begin
      prev = line_buf[line_len - 1];
      if (prev inside {[CHAR_ZERO:CHAR_TWO]}) begin
        line_buf[0] = prev;
        line_len    = 1;
      end
    end
    // Full buffer: the byte is dropped and the whole line thrown away.
    if (line_len < LINE_BUF_LEN - 1) begin
      line_buf[line_len] = c;
      line_len++;
    end else begin
      line_len = 0;
    end
  endtask

  // Sends one byte. Valid stays high across back-to-back words; it only
  // drops when a gap is drawn.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = idle_en ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    deframe_byte(b);
    if (b != CHAR_LF) begin
      bytes_sent++;
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i]);
    end
  endtask

  // Receiver: random stall before each word, then hold ready until taken.
  initial begin
    int unsigned stall;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = idle_en ? $urandom_range(0, MAX_IDLE) : 0;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Word checker: each accepted word against the oldest prediction.
  always @(posedge clk_i) begin : check_words
    line_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_words.size() == 0) begin
        $display("%0t: word with none expected: char %h kind %0d end %b", $realtime,
                 line_char_o, line_kind_o, line_end_o);
        fail_count++;
      end else begin
        want = pending_words.pop_front();
        if (line_char_o !== want.ch) begin
          $display("%0t: line_char expected %h actual %h", $realtime, want.ch,
                   line_char_o);
          fail_count++;
        end
        if (line_kind_o !== want.kind) begin
          $display("%0t: line_kind expected %0d actual %0d", $realtime, want.kind,
                   line_kind_o);
          fail_count++;
        end
        if (line_end_o !== want.last) begin
          $display("%0t: line_end expected %b actual %b", $realtime, want.last,
                   line_end_o);
          fail_count++;
        end
      end
    end
  end

  // Each tag kind, untagged line, and the byte extremes, back to back.
  task automatic test_line_kinds();
    idle_en = 1'b0;
    send_text("0:");
    send_byte(8'h00);
    send_byte(CHAR_CR);
    send_text("2:");
    send_byte(8'hFF);
    send_byte(CHAR_CR);
    send_text("1:a");
    send_byte(CHAR_CR);
    send_text("x");
    send_byte(CHAR_CR);
  endtask

  // Lone CR, bare tag, and an LF between CRs: none emit anything.
  task automatic test_empty_lines();
    idle_en = 1'b1;
    send_byte(CHAR_CR);
    send_text("1:");
    send_byte(CHAR_CR);
    send_byte(CHAR_LF);
    send_byte(CHAR_CR);
  endtask

  // Colon after a mid-line tag digit restarts the line as "1:c".
  task automatic test_resync_colon();
    send_text("ab1:c\n");
    send_byte(CHAR_CR);
  endtask

  // Longest line (63 words), then one that overflows and restarts.
  task automatic test_full_buffer();
    idle_en = 1'b1;
    repeat (LINE_BUF_LEN - 1) send_byte(8'($urandom_range(8'h41, 8'h5A)));
    send_byte(CHAR_CR);
    idle_en = 1'b0;
    repeat (LINE_BUF_LEN + 2) send_byte(8'($urandom_range(8'h41, 8'h5A)));
    send_byte(CHAR_CR);
  endtask

  // Mostly well-formed lines with random content; some near-miss tags,
  // stray colons, digits, LFs and raw bytes.
  task automatic test_random_lines(input int unsigned count);
    int unsigned stop_at;
    int unsigned shape;
    int unsigned body_len;
    int unsigned pick;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      idle_en = ($urandom_range(0, 3) != 0);
      shape   = $urandom_range(0, 9);
      if (shape < 6) begin
        send_byte(CHAR_ZERO + 8'($urandom_range(0, 2)));
        send_byte(CHAR_COLON);
      end else if (shape == 6) begin
        // Character just outside the tag digit range.
        send_byte($urandom_range(0, 1) ? CHAR_ZERO - 8'd1 : CHAR_TWO + 8'd1);
        send_byte(CHAR_COLON);
      end
      body_len = ($urandom_range(0, 19) == 0) ? $urandom_range(58, 70)
                                              : $urandom_range(0, 12);
      repeat (body_len) begin
        pick = $urandom_range(0, 19);
        case (pick)
          0: begin
            send_byte(CHAR_LF);
          end
          1: begin
            send_byte(CHAR_ZERO + 8'($urandom_range(0, 2)));
          end
          2: begin
            send_byte(CHAR_COLON);
          end
          3: begin
            send_byte(8'($urandom_range(0, 255)));
          end
          default: begin
            send_byte(8'($urandom_range(8'h20, 8'h7E)));
          end
        endcase
      end
      send_byte(CHAR_CR);
    end
  endtask

  // Raw noise over the whole byte range, then a CR to flush.
  task automatic test_noise(input int unsigned count);
    idle_en = 1'b1;
    repeat (count) send_byte(8'($urandom_range(0, 255)));
    send_byte(CHAR_CR);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_line_kinds();
    test_empty_lines();
    test_resync_colon();
    test_full_buffer();
    test_random_lines(200);
    test_noise(60);

    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/stld_pkg.sv
src/stld_line_ram.sv
src/serial_tagged_line_deframer_unit.sv
tb/sv/tb_serial_tagged_line_deframer_unit.sv
